@@ hw/rtl/paw_pkg.sv @@
// Package for the projected aperture overlap block: field widths, codes and shared types.
// Used by the channel interfaces and by every module under hw/rtl; depends on nothing.
package paw_pkg;

	localparam int NUM_UNITS_DEF = 3;
	localparam int SLOPE_FRAC_DEF = 16;

	localparam int POS_W = 13;
	localparam int EXT_W = 12;
	localparam int GAP_W = 10;
	localparam int UIDX_W = 2;
	localparam int PAIR_W = 2;
	localparam int Z_W = 15;
	localparam int DEN_W = 16;
	localparam int NUM_W = 16;
	localparam int EDGE_W = 14;
	localparam int OL_W = 20;
	localparam int FIFO_DEPTH = 4;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_QUERY = 1'b1;
	localparam logic AXIS_X = 1'b0;

	localparam logic [PAIR_W-1:0] PAIR_01 = 2'd0;
	localparam logic [PAIR_W-1:0] PAIR_02 = 2'd1;
	localparam logic [PAIR_W-1:0] PAIR_12 = 2'd2;

	localparam logic [UIDX_W-1:0] UNIT_0 = 2'd0;
	localparam logic [UIDX_W-1:0] UNIT_1 = 2'd1;
	localparam logic [UIDX_W-1:0] UNIT_2 = 2'd2;

	localparam logic [1:0] KIND_RUN = 2'd0;
	localparam logic [1:0] KIND_ZERO = 2'd1;
	localparam logic [1:0] KIND_DERR = 2'd2;

	typedef struct packed {
		logic signed [POS_W-1:0] x_org;
		logic signed [POS_W-1:0] y_org;
		logic [EXT_W-1:0] x_ext;
		logic [EXT_W-1:0] y_ext;
		logic signed [POS_W-1:0] czp;
		logic [GAP_W-1:0] gap;
		logic ord;
	} unit_t;

	typedef struct packed {
		logic [1:0] kind;
		logic signed [Z_W-1:0] z0lo;
		logic signed [Z_W-1:0] z0hi;
		logic signed [Z_W-1:0] z1lo;
		logic signed [Z_W-1:0] z1hi;
		logic signed [EDGE_W-1:0] lo0;
		logic signed [EDGE_W-1:0] hi0;
		logic signed [EDGE_W-1:0] lo1;
		logic signed [EDGE_W-1:0] hi1;
	} geo_t;

	typedef struct packed {
		geo_t geo;
		logic signed [NUM_W-1:0] num;
		logic signed [DEN_W-1:0] den;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

@@ hw/rtl/paw_in_if.sv @@
// Command channel of the projected aperture overlap block: loads and queries.
// Depends on paw_pkg for field widths.
interface paw_in_if;
	logic valid;
	logic ready;
	logic operation;
	logic [paw_pkg::UIDX_W-1:0] unit_index;
	logic signed [paw_pkg::POS_W-1:0] unit_x_origin;
	logic signed [paw_pkg::POS_W-1:0] unit_y_origin;
	logic [paw_pkg::EXT_W-1:0] unit_x_extent;
	logic [paw_pkg::EXT_W-1:0] unit_y_extent;
	logic signed [paw_pkg::POS_W-1:0] unit_depth_centre;
	logic [paw_pkg::GAP_W-1:0] unit_gap;
	logic unit_layer_order;
	logic axis_select;
	logic [paw_pkg::PAIR_W-1:0] unit_pair;
	logic signed [paw_pkg::POS_W-1:0] position_diff;

	modport source(output valid, operation, unit_index, unit_x_origin, unit_y_origin,
		unit_x_extent, unit_y_extent, unit_depth_centre, unit_gap, unit_layer_order,
		axis_select, unit_pair, position_diff, input ready);
	modport sink(input valid, operation, unit_index, unit_x_origin, unit_y_origin,
		unit_x_extent, unit_y_extent, unit_depth_centre, unit_gap, unit_layer_order,
		axis_select, unit_pair, position_diff, output ready);
endinterface

@@ hw/rtl/paw_out_if.sv @@
// Result channel of the projected aperture overlap block.
// Depends on paw_pkg for field widths.
interface paw_out_if;
	logic valid;
	logic ready;
	logic [paw_pkg::OL_W-1:0] overlap_length;
	logic depth_error;

	modport source(output valid, overlap_length, depth_error, input ready);
	modport sink(input valid, overlap_length, depth_error, output ready);
endinterface

@@ hw/rtl/paw_front.sv @@
// Front part: accepts items, keeps the unit geometry store and classifies queries into jobs.
// Depends on paw_pkg and paw_in_if.
module paw_front #(
	parameter int NUM_UNITS = paw_pkg::NUM_UNITS_DEF
) (
	input logic clk,
	input logic arst_n,
	paw_in_if.sink cmd,
	input paw_pkg::fifo_stat_t stat,
	output logic push,
	output paw_pkg::job_t job
);
	localparam int UW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
	localparam int ZW = paw_pkg::Z_W;
	localparam int DW = paw_pkg::DEN_W;
	localparam int NW = paw_pkg::NUM_W;
	localparam int EW = paw_pkg::EDGE_W;

	paw_pkg::unit_t unit_mem_q [NUM_UNITS];
	paw_pkg::unit_t rd0_s1, rd1_s1, g0, g1;
	logic ok0_s1, ok1_s1, axis_s1, v_s1, acc, wr_ok;
	logic [paw_pkg::PAIR_W-1:0] pair_s1;
	logic signed [paw_pkg::POS_W-1:0] diff_s1, pos0, pos1;
	logic [paw_pkg::EXT_W-1:0] ext0, ext1;
	logic [paw_pkg::UIDX_W-1:0] u0, u1;
	logic signed [ZW-1:0] zlo0, zhi0, zlo1, zhi1, zdet0, zdet1;
	logic signed [DW-1:0] den;
	logic signed [NW-1:0] num;

	assign push = v_s1 && !stat.full;
	assign cmd.ready = !v_s1 || !stat.full;
	assign acc = cmd.valid && cmd.ready;
	assign wr_ok = cmd.unit_index < NUM_UNITS;
	assign u0 = (cmd.unit_pair == paw_pkg::PAIR_12) ? paw_pkg::UNIT_1 : paw_pkg::UNIT_0;
	assign u1 = (cmd.unit_pair == paw_pkg::PAIR_01) ? paw_pkg::UNIT_1 : paw_pkg::UNIT_2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc && cmd.operation == paw_pkg::OP_QUERY) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && cmd.operation == paw_pkg::OP_LOAD && wr_ok) begin
			unit_mem_q[UW'(cmd.unit_index)] <= '{cmd.unit_x_origin, cmd.unit_y_origin,
				cmd.unit_x_extent, cmd.unit_y_extent, cmd.unit_depth_centre, cmd.unit_gap,
				cmd.unit_layer_order};
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd0_s1 <= unit_mem_q[UW'(u0)];
			rd1_s1 <= unit_mem_q[UW'(u1)];
			ok0_s1 <= u0 < NUM_UNITS;
			ok1_s1 <= u1 < NUM_UNITS;
			axis_s1 <= cmd.axis_select;
			pair_s1 <= cmd.unit_pair;
			diff_s1 <= cmd.position_diff;
		end
	end

	always_comb begin
		g0 = ok0_s1 ? rd0_s1 : '0;
		g1 = ok1_s1 ? rd1_s1 : '0;
		pos0 = (axis_s1 == paw_pkg::AXIS_X) ? g0.x_org : g0.y_org;
		pos1 = (axis_s1 == paw_pkg::AXIS_X) ? g1.x_org : g1.y_org;
		ext0 = (axis_s1 == paw_pkg::AXIS_X) ? g0.x_ext : g0.y_ext;
		ext1 = (axis_s1 == paw_pkg::AXIS_X) ? g1.x_ext : g1.y_ext;
		zlo0 = (ZW'(g0.czp) <<< 1) - ZW'(g0.gap);
		zhi0 = (ZW'(g0.czp) <<< 1) + ZW'(g0.gap);
		zlo1 = (ZW'(g1.czp) <<< 1) - ZW'(g1.gap);
		zhi1 = (ZW'(g1.czp) <<< 1) + ZW'(g1.gap);
		zdet0 = (g0.ord == axis_s1) ? zlo0 : zhi0;
		zdet1 = (g1.ord == axis_s1) ? zlo1 : zhi1;
		den = DW'(zdet0) - DW'(zdet1);
		num = (NW'(diff_s1) <<< 1) + (NW'(pos0) <<< 1) + NW'(ext0)
			- (NW'(pos1) <<< 1) - NW'(ext1);
		job.num = num;
		job.den = den;
		job.geo.z0lo = zlo0;
		job.geo.z0hi = zhi0;
		job.geo.z1lo = zlo1;
		job.geo.z1hi = zhi1;
		job.geo.lo0 = EW'(pos0);
		job.geo.hi0 = EW'(pos0) + EW'(ext0);
		job.geo.lo1 = EW'(pos1);
		job.geo.hi1 = EW'(pos1) + EW'(ext1);
		if (pair_s1 != paw_pkg::PAIR_01 && pair_s1 != paw_pkg::PAIR_02
			&& pair_s1 != paw_pkg::PAIR_12) begin
			job.geo.kind = paw_pkg::KIND_ZERO;
		end else if (den == '0) begin
			job.geo.kind = paw_pkg::KIND_DERR;
		end else begin
			job.geo.kind = paw_pkg::KIND_RUN;
		end
	end
endmodule

@@ hw/rtl/paw_fifo.sv @@
// Short job queue between the front and back parts.
// Depends on paw_pkg.
module paw_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input paw_pkg::job_t wr_job,
	input logic take,
	output paw_pkg::job_t rd_job,
	output paw_pkg::fifo_stat_t stat
);
	localparam int D = paw_pkg::FIFO_DEPTH;
	localparam int AW = $clog2(D);

	paw_pkg::job_t mem_q [D];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;

	assign stat.full = cnt_q == (AW + 1)'(D);
	assign stat.empty = cnt_q == '0;
	assign rd_job = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (take) begin
				rp_q <= rp_q + 1'b1;
			end
			case ({push, take})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_job;
		end
	end
endmodule

@@ hw/rtl/paw_div.sv @@
// Pipelined restoring divider for the slope: one quotient bit per stage, sign applied later.
// Depends on paw_pkg.
module paw_div #(
	parameter int FRAC = paw_pkg::SLOPE_FRAC_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input paw_pkg::job_t in_job,
	output logic out_valid,
	output logic [paw_pkg::NUM_W+FRAC-1:0] out_quo,
	output logic out_neg,
	output paw_pkg::geo_t out_geo
);
	localparam int NW = paw_pkg::NUM_W;
	localparam int DW = paw_pkg::DEN_W;
	localparam int QW = NW + FRAC;

	logic v_q [QW+1];
	logic neg_q [QW+1];
	logic [DW-1:0] rem_q [QW+1];
	logic [DW-1:0] dsr_q [QW+1];
	logic [QW-1:0] dvd_q [QW+1];
	logic [QW-1:0] quo_q [QW+1];
	paw_pkg::geo_t geo_q [QW+1];
	logic [NW-1:0] mag_num;
	logic [DW-1:0] mag_den;

	assign mag_num = in_job.num[NW-1] ? NW'(-in_job.num) : NW'(in_job.num);
	assign mag_den = in_job.den[DW-1] ? DW'(-in_job.den) : DW'(in_job.den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= '0;
			dvd_q[0] <= {mag_num, {FRAC{1'b0}}};
			quo_q[0] <= '0;
			dsr_q[0] <= mag_den;
			neg_q[0] <= in_job.num[NW-1] ^ in_job.den[DW-1];
			geo_q[0] <= in_job.geo;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW:0] trial, dif;
		logic ge;

		assign trial = {rem_q[k], dvd_q[k][QW-1]};
		assign dif = trial - {1'b0, dsr_q[k]};
		assign ge = !dif[DW];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1] <= ge ? dif[DW-1:0] : trial[DW-1:0];
				dvd_q[k+1] <= dvd_q[k] << 1;
				quo_q[k+1] <= {quo_q[k][QW-2:0], ge};
				dsr_q[k+1] <= dsr_q[k];
				neg_q[k+1] <= neg_q[k];
				geo_q[k+1] <= geo_q[k];
			end
		end
	end

	assign out_valid = v_q[QW];
	assign out_quo = quo_q[QW];
	assign out_neg = neg_q[QW];
	assign out_geo = geo_q[QW];
endmodule

@@ hw/rtl/paw_back.sv @@
// Back part: slope division, layer shifts, aperture intersection and the result register.
// Depends on paw_pkg, paw_out_if and paw_div.
module paw_back #(
	parameter int SLOPE_FRAC_BITS = paw_pkg::SLOPE_FRAC_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input paw_pkg::job_t in_job,
	output logic take,
	paw_out_if.source res
);
	localparam int F = SLOPE_FRAC_BITS;
	localparam int QW = paw_pkg::NUM_W + F;
	localparam int SW = QW + 1;
	localparam int PW = SW + paw_pkg::Z_W;
	localparam int XW = PW + 1;
	localparam int LW = paw_pkg::OL_W;

	logic en, dv, dneg;
	logic [QW-1:0] dquo;
	paw_pkg::geo_t dgeo, geo_s1, geo_s2, geo_s3;
	logic [1:0] kind_s4, kind_s5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, res_valid_q;
	logic signed [SW-1:0] slope_s1;
	logic signed [PW-1:0] sh_s2 [4];
	logic signed [XW-1:0] qmin_s3 [4];
	logic signed [XW-1:0] qmax_s3 [4];
	logic signed [XW-1:0] lo_a_s4, lo_b_s4, hi_a_s4, hi_b_s4, rmin_s5, rmax_s5, wd;
	logic [XW-F+6:0] wsh;
	logic [LW-1:0] len_q;
	logic derr_q;

	assign en = !res_valid_q || res.ready;
	assign take = en && in_valid;

	paw_div #(.FRAC(F)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid), .in_job(in_job),
		.out_valid(dv), .out_quo(dquo), .out_neg(dneg), .out_geo(dgeo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= dv;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			res_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			slope_s1 <= dneg ? -SW'(dquo) : SW'(dquo);
			geo_s1 <= dgeo;
			sh_s2[0] <= slope_s1 * geo_s1.z0lo;
			sh_s2[1] <= slope_s1 * geo_s1.z0hi;
			sh_s2[2] <= slope_s1 * geo_s1.z1lo;
			sh_s2[3] <= slope_s1 * geo_s1.z1hi;
			geo_s2 <= geo_s1;
			qmin_s3[0] <= (XW'(geo_s2.lo0) <<< (F + 1)) - XW'(sh_s2[0]);
			qmin_s3[1] <= (XW'(geo_s2.lo0) <<< (F + 1)) - XW'(sh_s2[1]);
			qmin_s3[2] <= (XW'(geo_s2.lo1) <<< (F + 1)) - XW'(sh_s2[2]);
			qmin_s3[3] <= (XW'(geo_s2.lo1) <<< (F + 1)) - XW'(sh_s2[3]);
			qmax_s3[0] <= (XW'(geo_s2.hi0) <<< (F + 1)) - XW'(sh_s2[0]);
			qmax_s3[1] <= (XW'(geo_s2.hi0) <<< (F + 1)) - XW'(sh_s2[1]);
			qmax_s3[2] <= (XW'(geo_s2.hi1) <<< (F + 1)) - XW'(sh_s2[2]);
			qmax_s3[3] <= (XW'(geo_s2.hi1) <<< (F + 1)) - XW'(sh_s2[3]);
			geo_s3 <= geo_s2;
			lo_a_s4 <= (qmin_s3[1] > qmin_s3[0]) ? qmin_s3[1] : qmin_s3[0];
			lo_b_s4 <= (qmin_s3[3] > qmin_s3[2]) ? qmin_s3[3] : qmin_s3[2];
			hi_a_s4 <= (qmax_s3[1] < qmax_s3[0]) ? qmax_s3[1] : qmax_s3[0];
			hi_b_s4 <= (qmax_s3[3] < qmax_s3[2]) ? qmax_s3[3] : qmax_s3[2];
			kind_s4 <= geo_s3.kind;
			rmin_s5 <= (lo_b_s4 > lo_a_s4) ? lo_b_s4 : lo_a_s4;
			rmax_s5 <= (hi_b_s4 < hi_a_s4) ? hi_b_s4 : hi_a_s4;
			kind_s5 <= kind_s4;
			if (kind_s5 != paw_pkg::KIND_RUN || rmin_s5 > rmax_s5) begin
				len_q <= '0;
			end else if (|wsh[XW-F+6:LW]) begin
				len_q <= '1;
			end else begin
				len_q <= wsh[LW-1:0];
			end
			derr_q <= kind_s5 == paw_pkg::KIND_DERR;
		end
	end

	assign wd = rmax_s5 - rmin_s5;
	assign wsh = wd[XW-1:F-7];

	assign res.valid = res_valid_q;
	assign res.overlap_length = len_q;
	assign res.depth_error = derr_q;
endmodule

@@ hw/rtl/projected_aperture_overlap.sv @@
// Projected aperture overlap: stores three detector units and answers overlap queries.
// The slope divider makes one quotient bit per stage. One item is accepted every cycle
// unless a query waits on a full job queue. Loads give no result. Reset clears all
// control state; the unit store is not cleared and a unit must be loaded before a
// query reads it.
module projected_aperture_overlap #(
	parameter int NUM_UNITS = paw_pkg::NUM_UNITS_DEF,
	parameter int SLOPE_FRAC_BITS = paw_pkg::SLOPE_FRAC_DEF
) (
	input logic clk,
	input logic arst_n,
	paw_in_if.sink cmd,
	paw_out_if.source res
);
	paw_pkg::fifo_stat_t stat;
	paw_pkg::job_t wr_job, rd_job;
	logic push, take;

	paw_front #(.NUM_UNITS(NUM_UNITS)) u_front (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .push(push), .job(wr_job)
	);

	paw_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wr_job(wr_job), .take(take),
		.rd_job(rd_job), .stat(stat)
	);

	paw_back #(.SLOPE_FRAC_BITS(SLOPE_FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(!stat.empty), .in_job(rd_job), .take(take),
		.res(res)
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.depth_error |-> res.overlap_length == '0)
		else $error("depth error result carries a nonzero length");

	a_fifo_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.full && stat.empty))
		else $error("job queue reports full and empty together");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("job pushed into a full queue");
endmodule
